/* rtl/dlpf_pkg.sv */
// ----------------------------------------------------------------------------
// dlpf_pkg: shared types and constants of the depth-first leaf path finder
// Node encoding, field widths, command codes and register indexes.
// ----------------------------------------------------------------------------
package dlpf_pkg;

  // Width of one node number as it travels on the ports and in the child lists.
  localparam int unsigned NODE_W = 4;
  // Width of the packed path, one node per nibble.
  localparam int unsigned PATH_W = 64;
  // Width of the path length field.
  localparam int unsigned LEN_W  = 5;
  // Width of the node count register.
  localparam int unsigned CFG_W  = 5;

  typedef logic [NODE_W-1:0] node_t;

  // Commands carried by the mode field of an input beat.
  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  // Register index, taken from the word address of the configuration port.
  localparam logic [1:0] REG_NODE_COUNT = 2'd0;

endpackage

/* rtl/dfs_leaf_path_finder_top.sv */
// ----------------------------------------------------------------------------
// dfs_leaf_path_finder_top: depth-first leaf path finder
// Loads a directed graph edge by edge and, on a search command, reports
// every root-to-leaf path found by a depth-first walk, then a done beat.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Contents
// s_axis    in         s_axis_tvalid/tready      command beat: mode, parent, child
// m_axis    out        m_axis_tvalid/tready      path beat, tlast on the done beat
// apb       in         psel/penable/pready       node_count register at address 0
//
// An add or clear beat completes in the cycle it is accepted. A search scans the root
// candidates, reads each child list entry from memory and then checks it as visited,
// returns to the parent level, or to the scan after each walk, sends a path beat per
// leaf and ends with the done beat; the single memory read port sets this order. The
// input is not ready during a search, and a stalled output holds the sequencer. Reset
// clears counts, flag and control state; node_count resets to 16.
//
module dfs_leaf_path_finder_top #(
  parameter int unsigned MAX_NODES    = 16,
  parameter int unsigned MAX_CHILDREN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // mode[1:0], parent[5:2], child[9:6]
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // path_packed[63:0], path_length[68:64],
                                      // leaf_node[72:69], list_overflow[73]
  output logic        m_axis_tlast,   // search_done
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW        = $clog2(MAX_CHILDREN + 1);
  localparam int unsigned MEM_DEPTH = MAX_NODES * MAX_CHILDREN;
  localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned DW        = $clog2(MAX_NODES + 1);
  localparam int unsigned LW        = $clog2(MAX_NODES);
  localparam int unsigned NW        = dlpf_pkg::NODE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_WALK,
    S_CHK,
    S_EMIT,
    S_DONE
  } state_e;

  state_e                         state_q;
  logic [dlpf_pkg::CFG_W-1:0]     node_count_q;
  logic [CW-1:0]                  cnt_q [MAX_NODES];
  logic [CW-1:0]                  nxt_q [MAX_NODES];
  logic [MAX_NODES-1:0]           visited_q;
  logic [dlpf_pkg::PATH_W-1:0]    path_q;
  logic [DW-1:0]                  depth_q;
  logic [DW-1:0]                  root_q;
  logic                           overflow_q;

  logic                           out_valid_q;
  logic [dlpf_pkg::PATH_W-1:0]    out_path_q;
  logic [dlpf_pkg::LEN_W-1:0]     out_len_q;
  dlpf_pkg::node_t                out_leaf_q;
  logic                           out_last_q;
  logic                           out_ovf_q;

  // Decoded input fields.
  logic [1:0]                     in_mode;
  dlpf_pkg::node_t                in_parent;
  dlpf_pkg::node_t                in_child;
  logic                           in_accept;

  logic [DW-1:0]                  n_eff;
  logic [LW-1:0]                  top_lvl;
  dlpf_pkg::node_t                top_node;
  logic [CW-1:0]                  top_next;
  logic [LW-1:0]                  cnt_addr;
  logic [CW-1:0]                  cnt_rd;
  logic                           out_free;
  logic                           out_load;
  logic                           apb_wr;
  logic                           add_in_range;
  logic                           child_ok;
  logic [dlpf_pkg::PATH_W-1:0]    path_masked;

  logic                           ram_wr_en;
  logic [AW-1:0]                  ram_wr_addr;
  logic                           ram_rd_en;
  logic [AW-1:0]                  ram_rd_addr;
  dlpf_pkg::node_t                ram_rd_data;

  assign in_mode   = s_axis_tdata[1:0];
  assign in_parent = s_axis_tdata[5:2];
  assign in_child  = s_axis_tdata[9:6];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3:2] == dlpf_pkg::REG_NODE_COUNT)
                  ? {{(32 - dlpf_pkg::CFG_W){1'b0}}, node_count_q} : 32'd0;

  // Effective node count: zero acts as one, anything above the limit saturates.
  always_comb begin
    if (node_count_q == '0) begin
      n_eff = DW'(1);
    end else if (node_count_q > dlpf_pkg::CFG_W'(MAX_NODES)) begin
      n_eff = DW'(MAX_NODES);
    end else begin
      n_eff = DW'(node_count_q);
    end
  end

  // The top of the walk stack. The node numbers of the stack live in the
  // path register, one nibble per level, so the path is always ready to send.
  assign top_lvl  = LW'(depth_q - DW'(1));
  assign top_node = path_q[NW*top_lvl +: NW];
  assign top_next = nxt_q[top_lvl];

  // One read of the child counts per cycle, addressed by what the current
  // state looks at.
  always_comb begin
    case (state_q)
      S_IDLE:  cnt_addr = in_parent[LW-1:0];
      S_ROOT:  cnt_addr = root_q[LW-1:0];
      S_CHK:   cnt_addr = ram_rd_data[LW-1:0];
      default: cnt_addr = top_node[LW-1:0];
    endcase
  end
  assign cnt_rd = cnt_q[cnt_addr];

  assign add_in_range = ({1'b0, in_parent} < dlpf_pkg::LEN_W'(n_eff)) &&
                        ({1'b0, in_child}  < dlpf_pkg::LEN_W'(n_eff));

  // A child just read from memory is entered if it is in range and unvisited.
  assign child_ok = ({1'b0, ram_rd_data} < dlpf_pkg::LEN_W'(n_eff)) &&
                    !visited_q[ram_rd_data[LW-1:0]];

  assign out_free = !out_valid_q || m_axis_tready;
  // The output register takes a new beat in this cycle.
  assign out_load = out_free && ((state_q == S_EMIT) || (state_q == S_DONE));

  // Child list memory access.
  always_comb begin
    ram_wr_en   = in_accept && (in_mode == dlpf_pkg::MODE_ADD) && add_in_range &&
                  (cnt_rd < CW'(MAX_CHILDREN));
    ram_wr_addr = AW'(int'(in_parent[LW-1:0]) * MAX_CHILDREN + int'(cnt_rd));
    ram_rd_en   = (state_q == S_WALK) && (depth_q != '0) && (top_next < cnt_rd);
    ram_rd_addr = AW'(int'(top_node[LW-1:0]) * MAX_CHILDREN + int'(top_next));
  end

  // Nibbles at and above the current depth are stale stack entries.
  always_comb begin
    for (int i = 0; i < dlpf_pkg::PATH_W / NW; i++) begin
      path_masked[NW*i +: NW] = (dlpf_pkg::LEN_W'(i) < dlpf_pkg::LEN_W'(depth_q))
                                ? path_q[NW*i +: NW] : '0;
    end
  end

  dlpf_child_ram #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_child_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (in_child),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // Sequencer and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= dlpf_pkg::CFG_W'(16);
      for (int i = 0; i < MAX_NODES; i++) begin
        cnt_q[i] <= '0;
        nxt_q[i] <= '0;
      end
      visited_q    <= '0;
      path_q       <= '0;
      depth_q      <= '0;
      root_q       <= '0;
      overflow_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_path_q   <= '0;
      out_len_q    <= '0;
      out_leaf_q   <= '0;
      out_last_q   <= 1'b0;
      out_ovf_q    <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      if (apb_wr && (paddr[3:2] == dlpf_pkg::REG_NODE_COUNT)) begin
        node_count_q <= pwdata[dlpf_pkg::CFG_W-1:0];
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            case (dlpf_pkg::mode_e'(in_mode))
              dlpf_pkg::MODE_ADD: begin
                if (add_in_range) begin
                  if (cnt_rd >= CW'(MAX_CHILDREN)) begin
                    overflow_q <= 1'b1;
                  end else begin
                    cnt_q[in_parent[LW-1:0]] <= cnt_rd + CW'(1);
                  end
                end
              end
              dlpf_pkg::MODE_SEARCH: begin
                visited_q <= '0;
                depth_q   <= '0;
                root_q    <= '0;
                state_q   <= S_ROOT;
              end
              dlpf_pkg::MODE_CLEAR: begin
                for (int i = 0; i < MAX_NODES; i++) begin
                  cnt_q[i] <= '0;
                end
                overflow_q <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end

        S_ROOT: begin
          if (root_q == n_eff) begin
            state_q <= S_DONE;
          end else if (visited_q[root_q[LW-1:0]]) begin
            root_q <= root_q + DW'(1);
          end else begin
            visited_q[root_q[LW-1:0]] <= 1'b1;
            path_q[NW-1:0]            <= NW'(root_q);
            nxt_q[0]                  <= '0;
            depth_q                   <= DW'(1);
            state_q                   <= (cnt_rd == '0) ? S_EMIT : S_WALK;
          end
        end

        S_WALK: begin
          if (depth_q == '0) begin
            root_q  <= root_q + DW'(1);
            state_q <= S_ROOT;
          end else if (top_next >= cnt_rd) begin
            depth_q <= depth_q - DW'(1);
          end else begin
            nxt_q[top_lvl] <= top_next + CW'(1);
            state_q        <= S_CHK;
          end
        end

        S_CHK: begin
          state_q <= S_WALK;
          if (child_ok) begin
            visited_q[ram_rd_data[LW-1:0]] <= 1'b1;
            if (depth_q < DW'(MAX_NODES)) begin
              path_q[NW*LW'(depth_q) +: NW] <= ram_rd_data;
              nxt_q[LW'(depth_q)]           <= '0;
              depth_q                       <= depth_q + DW'(1);
              if (cnt_rd == '0) begin
                state_q <= S_EMIT;
              end
            end
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_path_q  <= path_masked;
            out_len_q   <= dlpf_pkg::LEN_W'(depth_q);
            out_leaf_q  <= top_node;
            out_last_q  <= 1'b0;
            out_ovf_q   <= overflow_q;
            depth_q     <= depth_q - DW'(1);
            state_q     <= S_WALK;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_path_q  <= '0;
            out_len_q   <= '0;
            out_leaf_q  <= '0;
            out_last_q  <= 1'b1;
            out_ovf_q   <= overflow_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {6'd0, out_ovf_q, out_leaf_q, out_len_q, out_path_q};

  // The walk stack never grows past one level per node.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(MAX_NODES))
    else $error("walk stack deeper than the node limit");

  // The stack is empty whenever the block takes commands.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (depth_q == '0))
    else $error("walk stack not empty while idle");

  // A path beat always carries at least its root, the done beat carries none.
  a_path_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_len_q == '0) == out_last_q))
    else $error("path length disagrees with the done marker");

  // A search command starts the root scan in the next cycle.
  a_search_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_mode == dlpf_pkg::MODE_SEARCH)) |=> (state_q == S_ROOT))
    else $error("search command did not start the walk");

endmodule

/* rtl/dlpf_child_ram.sv */
// ----------------------------------------------------------------------------
// dlpf_child_ram: child list storage
// Simple dual-port memory of node numbers, with one write port and a registered read port.
// ----------------------------------------------------------------------------
module dlpf_child_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  dlpf_pkg::node_t      wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output dlpf_pkg::node_t      rd_data_o
);

  dlpf_pkg::node_t mem [DEPTH];
  dlpf_pkg::node_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* dv/dlpf_path_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dlpf_path_checker: scoreboard for the depth-first leaf path finder
// Mirrors the graph, the node count register and the overflow flag from the
// observed beats, predicts every path beat of a search and compares.
// ----------------------------------------------------------------------------
module dlpf_path_checker #(
  parameter int unsigned MAX_NODES    = 16,
  parameter int unsigned MAX_CHILDREN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [79:0] m_tdata_i,
  input  logic        m_tlast_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          err_cnt_o,
  output int          pending_o,
  output int          paths_o
);

  typedef struct packed {
    logic [dlpf_pkg::PATH_W-1:0] path;
    logic [dlpf_pkg::LEN_W-1:0]  len;
    dlpf_pkg::node_t             leaf;
    logic                        done;
    logic                        ovf;
  } path_beat_t;

  path_beat_t  path_q[$];

  dlpf_pkg::node_t kid_list [MAX_NODES][MAX_CHILDREN];
  int unsigned kid_cnt  [MAX_NODES];
  logic        ovf_flag;
  logic [dlpf_pkg::CFG_W-1:0] node_cfg;

  dlpf_pkg::node_t walk_node [MAX_NODES];
  int unsigned walk_next [MAX_NODES];

  int          beat_idx;

  function automatic int unsigned nodes_in_use();
    if (node_cfg == '0) return 1;
    if (node_cfg > MAX_NODES) return MAX_NODES;
    return node_cfg;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_cnt_o++;
    $display("[%0t] output beat %0d: %s is %0h, expected %0h",
             $time, beat_idx, what, got, want);
  endtask

  task automatic emit_path(input int unsigned depth);
    path_beat_t  b;
    int unsigned i;
    b = '0;
    for (i = 0; i < depth; i++)
      b.path |= dlpf_pkg::PATH_W'(walk_node[i]) << (4 * i);
    b.len  = dlpf_pkg::LEN_W'(depth);
    b.leaf = walk_node[depth-1];
    b.ovf  = ovf_flag;
    path_q = {path_q, b};
  endtask

  // Depth-first walk over the mirrored child lists, queueing one beat per
  // leaf reached and the closing done beat.
  task automatic predict_search();
    int unsigned     n, r, depth, lvl, c;
    logic [15:0]     seen;
    path_beat_t      fin;
    n    = nodes_in_use();
    seen = '0;
    for (r = 0; r < n; r++) begin
      if (!seen[r]) begin
        seen[r]      = 1'b1;
        walk_node[0] = dlpf_pkg::node_t'(r);
        walk_next[0] = 0;
        depth        = 1;
        if (kid_cnt[r] == 0) begin
          emit_path(1);
          depth = 0;
        end
        while (depth > 0) begin
          lvl = depth - 1;
          if (walk_next[lvl] >= kid_cnt[walk_node[lvl]]) begin
            depth--;
          end else begin
            c = kid_list[walk_node[lvl]][walk_next[lvl]];
            walk_next[lvl]++;
            // Children beyond the node count are skipped but still make
            // their parent a non-leaf.
            if (c < n && !seen[c]) begin
              seen[c] = 1'b1;
              if (depth < MAX_NODES) begin
                walk_node[depth] = dlpf_pkg::node_t'(c);
                walk_next[depth] = 0;
                depth++;
                if (kid_cnt[c] == 0) begin
                  emit_path(depth);
                  depth--;
                end
              end
            end
          end
        end
      end
    end
    fin      = '0;
    fin.done = 1'b1;
    fin.ovf  = ovf_flag;
    path_q   = {path_q, fin};
  endtask

  task automatic take_command(input logic [15:0] data);
    int unsigned n;
    dlpf_pkg::node_t p, c;
    n = nodes_in_use();
    p = data[5:2];
    c = data[9:6];
    case (data[1:0])
      dlpf_pkg::MODE_ADD: begin
        if (p < n && c < n) begin
          if (kid_cnt[p] >= MAX_CHILDREN) begin
            ovf_flag = 1'b1;
          end else begin
            kid_list[p][kid_cnt[p]] = c;
            kid_cnt[p]++;
          end
        end
      end
      dlpf_pkg::MODE_SEARCH: predict_search();
      dlpf_pkg::MODE_CLEAR: begin
        foreach (kid_cnt[i]) kid_cnt[i] = 0;
        ovf_flag = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic check_beat();
    path_beat_t want;
    if (path_q.size() == 0) begin
      report_mismatch("unexpected beat, data", m_tdata_i[63:0], 64'h0);
    end else begin
      want = path_q.pop_front();
      if (m_tdata_i[63:0] !== want.path)
        report_mismatch("path_packed", m_tdata_i[63:0], want.path);
      if (m_tdata_i[68:64] !== want.len)
        report_mismatch("path_length", 64'(m_tdata_i[68:64]), 64'(want.len));
      if (m_tdata_i[72:69] !== want.leaf)
        report_mismatch("leaf_node", 64'(m_tdata_i[72:69]), 64'(want.leaf));
      if (m_tlast_i !== want.done)
        report_mismatch("search_done", 64'(m_tlast_i), 64'(want.done));
      if (m_tdata_i[73] !== want.ovf)
        report_mismatch("list_overflow", 64'(m_tdata_i[73]), 64'(want.ovf));
    end
    if (!m_tlast_i) paths_o++;
    beat_idx++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_q.delete();
      foreach (kid_cnt[i]) kid_cnt[i] = 0;
      ovf_flag  = 1'b0;
      node_cfg  = dlpf_pkg::CFG_W'(16);
      err_cnt_o = 0;
      pending_o = 0;
      paths_o   = 0;
      beat_idx  = 0;
    end else begin
      // Output first, so a beat can never match an expectation queued by a
      // command accepted at the same edge.
      if (m_tvalid_i && m_tready_i) check_beat();
      if (s_tvalid_i && s_tready_i) take_command(s_tdata_i);
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[3:2] == dlpf_pkg::REG_NODE_COUNT)
        node_cfg = pwdata_i[dlpf_pkg::CFG_W-1:0];
      pending_o = path_q.size();
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the depth-first leaf path finder
// Loads random graphs edge by edge, launches searches under several node
// counts and flow-control settings, and leaves all checking to the checker.
// ----------------------------------------------------------------------------
module tb_top;

  // The fourth command code has no function; the block must swallow it.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // A register index the block does not implement; writes must be ignored.
  localparam logic [1:0] REG_SPARE   = 2'd1;

  localparam int QUIET_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 30;
  localparam int PHASES       = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;     // mode[1:0], parent[5:2], child[9:6]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;          // path_packed[63:0], path_length[68:64],
                                      // leaf_node[72:69], list_overflow[73]
  logic        m_axis_tlast;          // search_done
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          err_cnt, pending, paths_seen;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned cycles = 0;
  int unsigned cmds_sent = 0;
  int unsigned searches_sent = 0;
  int unsigned nodes_now = 16;

  // Node count settings, one per phase. Zero and values above sixteen test
  // the clamping; the phase order moves from large to small graphs and back
  // so that stored edges run out of range for later searches.
  int unsigned cfg_plan [PHASES] = '{16, 5, 1, 31, 9, 0, 17, 12};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  dfs_leaf_path_finder_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  dlpf_path_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tlast_i  (m_axis_tlast),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .pready_i   (pready),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending),
    .paths_o    (paths_seen)
  );

  // Output back-pressure. The stall chance is redrawn every cycle, so stalls
  // land on every state of the walk, including the done beat.
  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= rx_stall_pct);
  end

  // Watchdog. A hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still expected", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Phase 0 runs without gaps, 1 has an idle sender, 2 a stalling receiver
  // and 3 both at a lighter rate.
  task automatic set_pressure(input int unsigned sel);
    case (sel)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 66; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
      default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
    endcase
  endtask

  // Presents one command beat and returns at the edge where it is taken.
  // tvalid is only dropped when a gap is actually inserted, so back-to-back
  // beats never see two assignments to it in one time step.
  task automatic send_beat(input logic [1:0] mode, input dlpf_pkg::node_t parent,
                           input dlpf_pkg::node_t child);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, child, parent, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    if (mode != MODE_UNUSED) cmds_sent++;
    if (mode == dlpf_pkg::MODE_SEARCH) searches_sent++;
  endtask

  // Waits until every predicted beat has been delivered, then lets the block
  // settle, so that a register write lands while it is idle.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; pready is always high, so the register
  // is written at the edge that ends the access cycle.
  task automatic apb_write(input logic [1:0] index, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random graph session: an optional clear, a batch of edge loads with
  // some noise, sometimes a burst that overfills one list, then a search.
  task automatic graph_session();
    int unsigned cnt, k, roll;
    dlpf_pkg::node_t hot;
    if ($urandom_range(99) < 30)
      send_beat(dlpf_pkg::MODE_CLEAR, dlpf_pkg::node_t'($urandom_range(15)),
                dlpf_pkg::node_t'($urandom_range(15)));
    if ($urandom_range(99) < 12) begin
      hot = dlpf_pkg::node_t'($urandom_range(nodes_now - 1));
      for (k = 0; k < 17; k++)
        send_beat(dlpf_pkg::MODE_ADD, hot, dlpf_pkg::node_t'($urandom_range(nodes_now - 1)));
    end
    cnt = $urandom_range(1, nodes_now + 4);
    for (k = 0; k < cnt; k++) begin
      roll = $urandom_range(99);
      if (roll < 5)
        send_beat(MODE_UNUSED, dlpf_pkg::node_t'($urandom_range(15)),
                  dlpf_pkg::node_t'($urandom_range(15)));
      else if (roll < 14)
        send_beat(dlpf_pkg::MODE_ADD, dlpf_pkg::node_t'($urandom_range(15)),
                  dlpf_pkg::node_t'($urandom_range(15)));
      else
        send_beat(dlpf_pkg::MODE_ADD, dlpf_pkg::node_t'($urandom_range(nodes_now - 1)),
                  dlpf_pkg::node_t'($urandom_range(nodes_now - 1)));
    end
    send_beat(dlpf_pkg::MODE_SEARCH, dlpf_pkg::node_t'($urandom_range(15)),
              dlpf_pkg::node_t'($urandom_range(15)));
  endtask

  initial begin : stimulus
    int unsigned ph, k, start_cnt;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_pressure(0);
    apb_write(dlpf_pkg::REG_NODE_COUNT, 32'd16);

    // Directed part. An empty graph gives sixteen single-node paths; a chain
    // through all nodes back to the root fills every nibble of the stack but
    // has no leaf. The back edge and a duplicate edge are found visited and
    // skipped, the unused command is dropped, and a clear empties the graph.
    send_beat(dlpf_pkg::MODE_SEARCH, '0, '0);
    for (k = 0; k < 15; k++)
      send_beat(dlpf_pkg::MODE_ADD, dlpf_pkg::node_t'(k), dlpf_pkg::node_t'(k + 1));
    send_beat(dlpf_pkg::MODE_ADD, 4'd15, 4'd0);
    send_beat(dlpf_pkg::MODE_ADD, 4'd0, 4'd1);
    send_beat(MODE_UNUSED, 4'hF, 4'hF);
    send_beat(dlpf_pkg::MODE_SEARCH, 4'hF, 4'hF);
    send_beat(dlpf_pkg::MODE_CLEAR, '0, '0);
    send_beat(dlpf_pkg::MODE_SEARCH, '0, '0);
    wait_quiet();

    // A write to an unimplemented register must leave node_count alone.
    apb_write(REG_SPARE, 32'd3);

    // Random part. Each phase starts with a search over the graph left from
    // the previous phase, so stored children beyond a reduced node count are
    // walked past as well.
    for (ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      set_pressure(ph % 4);
      apb_write(dlpf_pkg::REG_NODE_COUNT, {27'($urandom), cfg_plan[ph][4:0]});
      nodes_now = (cfg_plan[ph] == 0) ? 1 : ((cfg_plan[ph] > 16) ? 16 : cfg_plan[ph]);
      start_cnt = cmds_sent;
      send_beat(dlpf_pkg::MODE_SEARCH, '0, '0);
      while (cmds_sent - start_cnt < PHASE_ITEMS) graph_session();
    end

    set_pressure(0);
    wait_quiet();
    repeat (QUIET_CYCLES) @(posedge clk_i);

    $display("Sent %0d commands including %0d searches over %0d node count settings.",
             cmds_sent, searches_sent, PHASES + 1);
    $display("Checked %0d leaf paths plus a done beat per search, %0d mismatches.",
             paths_seen, err_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dlpf_pkg.sv
rtl/dlpf_child_ram.sv
rtl/dfs_leaf_path_finder_top.sv
dv/dlpf_path_checker.sv
dv/tb_top.sv
